>>> hdl/cidsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CMOS index/data shadow filter package
// Types, codes and sizes that the controller, the datapath and the top level
// all use.
// ----------------------------------------------------------------------------
package cidsf_pkg;

   // Shadow store geometry: two banks of 128 bytes.
   localparam int SHADOW_BYTES      = 256;
   localparam int SHADOW_ADDR_WIDTH = 8;
   localparam int INDEX_WIDTH       = 7;
   localparam int PORT_WIDTH        = 16;
   localparam int DATA_WIDTH        = 8;
   localparam int MASK_WIDTH        = 64;
   localparam int MASK_COUNT        = 4;
   localparam int CSR_INDEX_WIDTH   = 3;

   // Access kinds.
   localparam logic ACTION_READ  = 1'b0;
   localparam logic ACTION_WRITE = 1'b1;

   // Latched bank codes.
   localparam logic [1:0] BANK_NONE = 2'd0;
   localparam logic [1:0] BANK_LOW  = 2'd1;
   localparam logic [1:0] BANK_HIGH = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROTECT_MASK_0 = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROTECT_MASK_1 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROTECT_MASK_2 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROTECT_MASK_3 = 3'd3;

   // One port access from the processor.
   typedef struct packed {
      logic                  action;
      logic [PORT_WIDTH-1:0] port;
      logic [DATA_WIDTH-1:0] write_data;
      logic [DATA_WIDTH-1:0] device_read_data;
   } req_type;

   // Outcome of one port access.
   typedef struct packed {
      logic [DATA_WIDTH-1:0] read_data;
      logic                  forward_write;
      logic                  dummy_read;
      logic                  shadow_hit;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

endpackage

>>> hdl/cidsf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module cidsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/cidsf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CMOS index/data shadow filter controller
// Sequences each access through a capture cycle and a commit cycle and owns
// the result valid flag.
// ----------------------------------------------------------------------------
module cidsf_ctrl
   import cidsf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The output register can take a new result when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid: set on commit, cleared once the transfer completes.
   assign rsp_valid_in = cmd.commit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hdl/cidsf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CMOS index/data shadow filter datapath
// Holds the index latch, the protection masks and the shadow store, and
// works out the result of each access.
// ----------------------------------------------------------------------------
module cidsf_datapath
   import cidsf_pkg::*;
#(
   parameter logic [15:0] INDEX_PORT_LOW  = 16'd112,
   parameter logic [15:0] DATA_PORT_LOW   = 16'd113,
   parameter logic [15:0] INDEX_PORT_HIGH = 16'd114,
   parameter logic [15:0] DATA_PORT_HIGH  = 16'd115
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   input  req_type                    req_data,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [MASK_WIDTH-1:0]      csr_write_data,
   output rsp_type                    rsp_data
);

   localparam logic SHARED_INDEX_PORT = (INDEX_PORT_LOW == INDEX_PORT_HIGH);

   logic [MASK_WIDTH-1:0]        mask_ff [MASK_COUNT];
   logic [1:0]                   bank_ff, bank_in;
   logic [INDEX_WIDTH-1:0]       index_ff, index_in;
   logic [SHADOW_BYTES-1:0]      valid_ff;
   req_type                      req_ff;
   rsp_type                      rsp_ff, rsp_in;

   logic                         bank_high;
   logic                         bank_low;
   logic [SHADOW_ADDR_WIDTH-1:0] addr;
   logic                         is_protected;
   logic [DATA_WIDTH-1:0]        ram_q;
   logic [DATA_WIDTH-1:0]        shadow_byte;
   logic                         is_index_port;
   logic                         is_data_port;
   logic                         ram_wr_en;

   // Configuration writes; indexes beyond the mask list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MASK_COUNT; i++) begin
            mask_ff[i] <= '0;
         end
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PROTECT_MASK_0: mask_ff[0] <= csr_write_data;
            CSR_PROTECT_MASK_1: mask_ff[1] <= csr_write_data;
            CSR_PROTECT_MASK_2: mask_ff[2] <= csr_write_data;
            CSR_PROTECT_MASK_3: mask_ff[3] <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Byte address selected by the latch; when the index ports share a
   // number, a high-bank latch also counts as the low bank.
   assign bank_high = (bank_ff == BANK_HIGH);
   assign bank_low  = (bank_ff == BANK_LOW) || (bank_high && SHARED_INDEX_PORT);
   assign addr      = {bank_high, index_ff};
   assign is_protected = mask_ff[addr[7:6]][addr[5:0]];

   // Port decoding of the captured access.
   assign is_index_port = (req_ff.port == INDEX_PORT_LOW) ||
                          (req_ff.port == INDEX_PORT_HIGH);
   assign is_data_port  = (req_ff.port == DATA_PORT_LOW) ||
                          (req_ff.port == DATA_PORT_HIGH);

   // A byte never written since reset reads as zero.
   assign shadow_byte = valid_ff[addr] ? ram_q : '0;

   // Result and latch update for the captured access.
   always_comb begin
      rsp_in    = '0;
      bank_in   = bank_ff;
      index_in  = index_ff;
      ram_wr_en = 1'b0;
      if (req_ff.action == ACTION_READ) begin
         rsp_in.read_data = req_ff.device_read_data;
         if (is_data_port && (bank_low || bank_high)) begin
            if (is_protected) begin
               rsp_in.read_data  = shadow_byte;
               rsp_in.shadow_hit = 1'b1;
            end
            bank_in = BANK_NONE;
         end
      end else begin
         if (is_index_port) begin
            bank_in  = (req_ff.port == INDEX_PORT_HIGH) ? BANK_HIGH : BANK_LOW;
            index_in = req_ff.write_data[INDEX_WIDTH-1:0];
         end else if (is_data_port && (bank_ff != BANK_NONE)) begin
            if (((bank_low && (req_ff.port == DATA_PORT_LOW)) ||
                 (bank_high && (req_ff.port == DATA_PORT_HIGH))) && is_protected) begin
               ram_wr_en = 1'b1;
            end
            bank_in = BANK_NONE;
         end
         rsp_in.forward_write = !ram_wr_en;
         rsp_in.dummy_read    = ram_wr_en;
         rsp_in.shadow_hit    = ram_wr_en;
      end
   end

   // Latch and shadow valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff  <= BANK_NONE;
         index_ff <= '0;
         valid_ff <= '0;
      end else if (cmd.commit) begin
         bank_ff  <= bank_in;
         index_ff <= index_in;
         if (ram_wr_en) begin
            valid_ff[addr] <= 1'b1;
         end
      end
   end

   // Captured access and output register.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   // Shadow store: read at the latched address while the access is captured.
   cidsf_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (SHADOW_BYTES)
   ) u_shadow_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en & cmd.commit),
      .wr_addr (addr),
      .wr_data (req_ff.write_data),
      .rd_en   (cmd.capture),
      .rd_addr (addr),
      .rd_data (ram_q)
   );

   assign rsp_data = rsp_ff;

endmodule

>>> hdl/cmos_index_data_shadow_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CMOS index/data shadow filter
// Filters processor accesses to a two-bank CMOS RTC and keeps protected
// bytes in a local shadow store.
// ----------------------------------------------------------------------------
// The block handles one port access at a time: in the cycle of the request
// transfer the shadow store is read at the latched address, and once the
// output register is free the access is decoded, the latch and store are
// updated and the result is loaded into the output register. A new request
// can be taken in the cycle after that, and not before the last access has
// been committed. The result register lets the next request be taken while
// a result still waits; if a second result is ready before the first has
// been taken, the block holds it and stalls requests. Shadow bytes read as
// zero until first written, tracked by per-byte valid bits, so no clearing
// pass is needed after reset. Mask writes are taken at any time the block
// is idle.
// ----------------------------------------------------------------------------
module cmos_index_data_shadow_filter
   import cidsf_pkg::*;
#(
   parameter logic [15:0] INDEX_PORT_LOW  = 16'd112,
   parameter logic [15:0] DATA_PORT_LOW   = 16'd113,
   parameter logic [15:0] INDEX_PORT_HIGH = 16'd114,
   parameter logic [15:0] DATA_PORT_HIGH  = 16'd115
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_type                    rsp_data,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [MASK_WIDTH-1:0]      csr_write_data
);

   cmd_type cmd;

   // Sequencing of each access.
   cidsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Latch, masks, shadow store and result register.
   cidsf_datapath #(
      .INDEX_PORT_LOW  (INDEX_PORT_LOW),
      .DATA_PORT_LOW   (DATA_PORT_LOW),
      .INDEX_PORT_HIGH (INDEX_PORT_HIGH),
      .DATA_PORT_HIGH  (DATA_PORT_HIGH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_data         (rsp_data)
   );

endmodule
